@@ sv/vlm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, widths and constants for the voice level meter.
// No dependencies; every other file of the block imports this package.
package vlm_pkg;

  localparam int unsigned MAX_FRAME_SAMPLES = 4096;
  localparam int unsigned LEVEL_MAX         = 100;
  localparam int unsigned FULL_SCALE_LEVEL  = 8000;
  localparam int unsigned LEVEL_SCALE       = 100;
  // floor(floor(s / n) * 100 / 8000) == floor(s / (n * 80))
  localparam int unsigned LEVEL_DIV         = FULL_SCALE_LEVEL / LEVEL_SCALE;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned ABS_W      = SAMPLE_W + 1;
  localparam int unsigned SUM_W      = 28;
  localparam int unsigned CNT_W      = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int unsigned DIVISOR_W  = $clog2(MAX_FRAME_SAMPLES * LEVEL_DIV + 1);
  localparam int unsigned STEP_W     = $clog2(SUM_W);
  localparam int unsigned LEVEL_W    = 7;
  localparam int unsigned HOLD_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // Channel selection codes of the stereo mask register
  localparam logic [1:0] MASK_NONE  = 2'd0;
  localparam logic [1:0] MASK_LEFT  = 2'd1;
  localparam logic [1:0] MASK_RIGHT = 2'd2;
  localparam logic [1:0] MASK_BOTH  = 2'd3;

  localparam logic [LEVEL_W-1:0] THRESHOLD_RST = 7'd10;
  localparam logic [HOLD_W-1:0]  HOLD_RST      = 16'd1500;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEREO_INPUT    = 2'd0,
    REG_STEREO_MASK     = 2'd1,
    REG_VOICE_THRESHOLD = 2'd2,
    REG_HOLD_TICKS      = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic               stereo_input;
    logic [1:0]         stereo_mask;
    logic [LEVEL_W-1:0] voice_threshold;
    logic [HOLD_W-1:0]  hold_ticks;
  } cfg_t;

  // One job handed from the front to the back: a tick or a closed frame
  typedef struct packed {
    logic             is_frame;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } job_t;

  typedef struct packed {
    logic                 start;
    logic [SUM_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [ABS_W-1:0] rectify(input logic [SAMPLE_W-1:0] v);
    logic [ABS_W-1:0] ext;
    ext = {1'b0, v};
    if (v[SAMPLE_W-1]) begin
      return (ABS_W'(1) << SAMPLE_W) - ext;
    end
    return ext;
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                               input logic [ABS_W-1:0] x);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + (SUM_W + 1)'(x);
    if (s[SUM_W]) begin
      return SUM_MAX;
    end
    return s[SUM_W-1:0];
  endfunction

endpackage

@@ sv/vlm_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts beats, rectifies and sums samples, closes frames.
// Depends on vlm_pkg; feeds jobs into vlm_queue.
module vlm_front
  import vlm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic                action,
  input  logic [SAMPLE_W-1:0] left_sample,
  input  logic [SAMPLE_W-1:0] right_sample,
  input  logic                last_in_frame,
  input  logic                full,
  output logic                push,
  output job_t                job
);

  logic [SUM_W-1:0] left_sum, right_sum;
  logic [CNT_W-1:0] frame_count;
  logic [SUM_W-1:0] left_next, right_next;
  logic [CNT_W-1:0] count_next;
  logic [SUM_W:0]   pair;
  logic [SUM_W-1:0] chosen;
  logic             in_room;
  logic             accept;

  assign s_tready = !full;
  assign accept   = s_tvalid && !full;

  always_comb begin
    in_room    = frame_count < CNT_W'(MAX_FRAME_SAMPLES);
    left_next  = in_room ? sat_add(left_sum, rectify(left_sample)) : left_sum;
    right_next = (in_room && cfg.stereo_input) ?
                 sat_add(right_sum, rectify(right_sample)) : right_sum;
    count_next = in_room ? frame_count + CNT_W'(1) : frame_count;
    pair       = {1'b0, left_next} + {1'b0, right_next};
    chosen     = left_next;
    if (cfg.stereo_input) begin
      unique case (cfg.stereo_mask)
        MASK_NONE:  chosen = '0;
        MASK_LEFT:  chosen = left_next;
        MASK_RIGHT: chosen = right_next;
        MASK_BOTH:  chosen = pair[SUM_W:1];
        default:    chosen = '0;
      endcase
    end
  end

  assign push         = accept && (action || last_in_frame);
  assign job.is_frame = !action;
  assign job.sum      = chosen;
  assign job.count    = count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_sum    <= '0;
      right_sum   <= '0;
      frame_count <= '0;
    end else if (accept && !action) begin
      if (last_in_frame) begin
        left_sum    <= '0;
        right_sum   <= '0;
        frame_count <= '0;
      end else begin
        left_sum    <= left_next;
        right_sum   <= right_next;
        frame_count <= count_next;
      end
    end
  end

endmodule

@@ sv/vlm_queue.sv @@
`timescale 1ns / 1ps
// Short job queue between the front and the back end.
// Depends on vlm_pkg for the job type and depth.
module vlm_queue
  import vlm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head_job,
  output logic full,
  output logic empty
);

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full     = fill == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign empty    = fill == '0;
  assign head_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      fill <= fill + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end
  end

endmodule

@@ sv/vlm_divider.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Depends on vlm_pkg for widths and request/response types.
module vlm_divider
  import vlm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] divisor;
  logic [SUM_W-1:0]     quo;
  logic [STEP_W-1:0]    step;
  logic                 running;
  logic                 done;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 fits;

  always_comb begin
    trial = {rem, quo[SUM_W-1]};
    diff  = trial - {1'b0, divisor};
    fits  = trial >= {1'b0, divisor};
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
      step    <= '0;
    end else if (running) begin
      rem  <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo  <= {quo[SUM_W-2:0], fits};
      step <= step + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
      end else if (running && step == STEP_W'(SUM_W - 1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

endmodule

@@ sv/vlm_back.sv @@
`timescale 1ns / 1ps
// Back end: turns ticks and closed frames into results, owns level and hold.
// Depends on vlm_pkg; instantiates vlm_divider.
module vlm_back
  import vlm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  job_t               job,
  input  logic               empty,
  output logic               pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [LEVEL_W-1:0] level,
  output logic               voice_active,
  output logic               frame_done
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t             state;
  logic [LEVEL_W-1:0] cur_level;
  logic [HOLD_W-1:0]  hold;
  logic [HOLD_W-1:0]  hold_dec;
  logic               div_zero;
  logic               out_free;
  logic               load_out;
  logic [LEVEL_W-1:0] new_level;
  logic               new_meet;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  vlm_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    out_free         = !m_tvalid || m_tready;
    pop              = (state == ST_IDLE) && !empty && (job.is_frame || out_free);
    load_out         = (pop && !job.is_frame) || ((state == ST_EMIT) && out_free);
    div_req.start    = pop && job.is_frame;
    div_req.dividend = job.sum;
    div_req.divisor  = DIVISOR_W'(job.count) * DIVISOR_W'(LEVEL_DIV);
    hold_dec         = (hold != '0) ? hold - HOLD_W'(1) : hold;
    if (div_zero) begin
      new_level = '0;
    end else if (div_rsp.quotient > SUM_W'(LEVEL_MAX)) begin
      new_level = LEVEL_W'(LEVEL_MAX);
    end else begin
      new_level = div_rsp.quotient[LEVEL_W-1:0];
    end
    new_meet = new_level >= cfg.voice_threshold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur_level <= '0;
      hold      <= '0;
      div_zero  <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      m_tvalid <= load_out || (m_tvalid && !m_tready);
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            if (job.is_frame) begin
              div_zero <= job.count == '0;
              state    <= ST_DIV;
            end else begin
              hold         <= hold_dec;
              level        <= cur_level;
              voice_active <= (cur_level >= cfg.voice_threshold) || (hold_dec != '0);
              frame_done   <= 1'b0;
            end
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            cur_level <= new_level;
            if (new_meet) begin
              hold <= cfg.hold_ticks;
            end
            level        <= new_level;
            voice_active <= new_meet || (hold != '0);
            frame_done   <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ sv/voice_level_meter_with_hold.sv @@
`timescale 1ns / 1ps
// Voice level meter with hold. Sample beats are rectified and summed per
// channel; the beat with tlast closes the frame, whose chosen sum is divided
// by the frame's sample count, scaled by 100/8000 and clamped at 100 to give
// the level. A level at or above the threshold reloads the hold counter,
// which each millisecond tick beat counts down; voice is active while the
// level meets the threshold or hold is nonzero. Every tick and every frame
// end gives one result beat. Rate: sample beats are taken one per cycle
// whenever the four-entry job queue has room; a tick job's result is
// registered on pop, a frame-end job's after the 28-step restoring divider.
// Users must write configuration only while the block is idle; not enforced.
// Depends on vlm_pkg, vlm_front, vlm_queue, vlm_divider and vlm_back.
module voice_level_meter_with_hold
  import vlm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input beats
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,   // [15:0] left_sample, [31:16] right_sample
  input  logic                  s_tuser,   // [0] action: 0 sample, 1 tick
  input  logic                  s_tlast,   // last_in_frame
  // result beats
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // [6:0] level, [7] voice_active
  output logic                  m_tuser    // [0] frame_done
);

  cfg_t               cfg;
  logic               push, pop, full, empty;
  job_t               push_job, head_job;
  logic [LEVEL_W-1:0] level;
  logic               voice_active;

  // Hold configuration registers; unknown indexes fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stereo_input    <= 1'b0;
      cfg.stereo_mask     <= MASK_BOTH;
      cfg.voice_threshold <= THRESHOLD_RST;
      cfg.hold_ticks      <= HOLD_RST;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_STEREO_INPUT:    cfg.stereo_input    <= cfg_data[0];
        REG_STEREO_MASK:     cfg.stereo_mask     <= cfg_data[1:0];
        REG_VOICE_THRESHOLD: cfg.voice_threshold <= cfg_data[LEVEL_W-1:0];
        REG_HOLD_TICKS:      cfg.hold_ticks      <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: sum samples, close frames, forward ticks
  vlm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .action        (s_tuser),
    .left_sample   (s_tdata[15:0]),
    .right_sample  (s_tdata[31:16]),
    .last_in_frame (s_tlast),
    .full          (full),
    .push          (push),
    .job           (push_job)
  );

  // Decouple the sides so a long divide stalls sample intake only if the queue fills
  vlm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .full     (full),
    .empty    (empty)
  );

  // Back: divide, clamp, update hold, register the result beat
  vlm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .job          (head_job),
    .empty        (empty),
    .pop          (pop),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .level        (level),
    .voice_active (voice_active),
    .frame_done   (m_tuser)
  );

  assign m_tdata = {voice_active, level};

endmodule

@@ sv/vlm_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the voice level meter, bound to the top level.
// Depends on vlm_pkg and voice_level_meter_with_hold.
module vlm_checker
  import vlm_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tuser
);

  logic [LEVEL_W-1:0] prev_level;

  // Track the level of the latest delivered result
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level <= '0;
    end else if (m_tvalid && m_tready) begin
      prev_level <= m_tdata[LEVEL_W-1:0];
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result beat changed");

  a_level_clamp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[LEVEL_W-1:0] <= LEVEL_W'(LEVEL_MAX))
    else $error("level above clamp");

  a_tick_keeps_level: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tuser |-> m_tdata[LEVEL_W-1:0] == prev_level)
    else $error("tick result changed the level");

endmodule

bind voice_level_meter_with_hold vlm_checker u_checker (.*);
